[rtl/rtn_pkg.sv]
package rtn_pkg;

    localparam int TAG_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF = 16;

    localparam int COORD_W   = 32;
    localparam int VEC_W     = COORD_W + 1;
    localparam int PQ_W      = 2 * VEC_W + 1;
    localparam int LO_W      = 34;
    localparam int MB_W      = 35;
    localparam int PROD_W    = VEC_W + MB_W;
    localparam int ACC_W     = 104;
    localparam int Q_W       = 32;
    localparam int UOP_COUNT = 36;
    localparam int UOP_CNT_W = $clog2(UOP_COUNT);
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DET_EPS  = 3'd6;

    localparam logic [COORD_W-1:0] DIR_Z_RST   = 32'd65536;
    localparam logic [COORD_W-1:0] DET_EPS_RST = 32'd281474977;

    typedef enum logic [4:0] {
        OPD_E1X, OPD_E1Y, OPD_E1Z,
        OPD_E2X, OPD_E2Y, OPD_E2Z,
        OPD_SX,  OPD_SY,  OPD_SZ,
        OPD_DX,  OPD_DY,  OPD_DZ,
        OPD_PX,  OPD_PY,  OPD_PZ,
        OPD_QX,  OPD_QY,  OPD_QZ
    } t_opnd;

    typedef enum logic [3:0] {
        DST_PX, DST_PY, DST_PZ, DST_QX, DST_QY, DST_QZ,
        DST_DET, DST_U, DST_V, DST_NUM
    } t_dst;

    typedef struct packed {
        t_opnd a;
        t_opnd b;
        logic  hi;
        logic  sub;
        logic  first;
        logic  last;
        t_dst  dst;
    } t_uop;

    typedef struct packed {
        logic load;
        logic issue;
        t_uop uop;
        logic check;
        logic div_init;
        logic div_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic cand;
    } t_sts;

    function automatic t_uop mk_uop(t_opnd a, t_opnd b, logic hi, logic sub,
                                    logic first, logic last, t_dst dst);
        t_uop u;
        u.a     = a;
        u.b     = b;
        u.hi    = hi;
        u.sub   = sub;
        u.first = first;
        u.last  = last;
        u.dst   = dst;
        return u;
    endfunction

    // Cross products first (one product per step), then the four dot products
    // against the 67-bit vectors, each split into a low and a high chunk.
    function automatic t_uop uop_rom(logic [UOP_CNT_W-1:0] idx);
        t_uop u;
        unique case (idx)
            6'd0:  u = mk_uop(OPD_DY,  OPD_E2Z, 1'b0, 1'b0, 1'b1, 1'b0, DST_PX);
            6'd1:  u = mk_uop(OPD_DZ,  OPD_E2Y, 1'b0, 1'b1, 1'b0, 1'b1, DST_PX);
            6'd2:  u = mk_uop(OPD_DZ,  OPD_E2X, 1'b0, 1'b0, 1'b1, 1'b0, DST_PY);
            6'd3:  u = mk_uop(OPD_DX,  OPD_E2Z, 1'b0, 1'b1, 1'b0, 1'b1, DST_PY);
            6'd4:  u = mk_uop(OPD_DX,  OPD_E2Y, 1'b0, 1'b0, 1'b1, 1'b0, DST_PZ);
            6'd5:  u = mk_uop(OPD_DY,  OPD_E2X, 1'b0, 1'b1, 1'b0, 1'b1, DST_PZ);
            6'd6:  u = mk_uop(OPD_SY,  OPD_E1Z, 1'b0, 1'b0, 1'b1, 1'b0, DST_QX);
            6'd7:  u = mk_uop(OPD_SZ,  OPD_E1Y, 1'b0, 1'b1, 1'b0, 1'b1, DST_QX);
            6'd8:  u = mk_uop(OPD_SZ,  OPD_E1X, 1'b0, 1'b0, 1'b1, 1'b0, DST_QY);
            6'd9:  u = mk_uop(OPD_SX,  OPD_E1Z, 1'b0, 1'b1, 1'b0, 1'b1, DST_QY);
            6'd10: u = mk_uop(OPD_SX,  OPD_E1Y, 1'b0, 1'b0, 1'b1, 1'b0, DST_QZ);
            6'd11: u = mk_uop(OPD_SY,  OPD_E1X, 1'b0, 1'b1, 1'b0, 1'b1, DST_QZ);
            6'd12: u = mk_uop(OPD_E1X, OPD_PX,  1'b0, 1'b0, 1'b1, 1'b0, DST_DET);
            6'd13: u = mk_uop(OPD_E1X, OPD_PX,  1'b1, 1'b0, 1'b0, 1'b0, DST_DET);
            6'd14: u = mk_uop(OPD_E1Y, OPD_PY,  1'b0, 1'b0, 1'b0, 1'b0, DST_DET);
            6'd15: u = mk_uop(OPD_E1Y, OPD_PY,  1'b1, 1'b0, 1'b0, 1'b0, DST_DET);
            6'd16: u = mk_uop(OPD_E1Z, OPD_PZ,  1'b0, 1'b0, 1'b0, 1'b0, DST_DET);
            6'd17: u = mk_uop(OPD_E1Z, OPD_PZ,  1'b1, 1'b0, 1'b0, 1'b1, DST_DET);
            6'd18: u = mk_uop(OPD_SX,  OPD_PX,  1'b0, 1'b0, 1'b1, 1'b0, DST_U);
            6'd19: u = mk_uop(OPD_SX,  OPD_PX,  1'b1, 1'b0, 1'b0, 1'b0, DST_U);
            6'd20: u = mk_uop(OPD_SY,  OPD_PY,  1'b0, 1'b0, 1'b0, 1'b0, DST_U);
            6'd21: u = mk_uop(OPD_SY,  OPD_PY,  1'b1, 1'b0, 1'b0, 1'b0, DST_U);
            6'd22: u = mk_uop(OPD_SZ,  OPD_PZ,  1'b0, 1'b0, 1'b0, 1'b0, DST_U);
            6'd23: u = mk_uop(OPD_SZ,  OPD_PZ,  1'b1, 1'b0, 1'b0, 1'b1, DST_U);
            6'd24: u = mk_uop(OPD_DX,  OPD_QX,  1'b0, 1'b0, 1'b1, 1'b0, DST_V);
            6'd25: u = mk_uop(OPD_DX,  OPD_QX,  1'b1, 1'b0, 1'b0, 1'b0, DST_V);
            6'd26: u = mk_uop(OPD_DY,  OPD_QY,  1'b0, 1'b0, 1'b0, 1'b0, DST_V);
            6'd27: u = mk_uop(OPD_DY,  OPD_QY,  1'b1, 1'b0, 1'b0, 1'b0, DST_V);
            6'd28: u = mk_uop(OPD_DZ,  OPD_QZ,  1'b0, 1'b0, 1'b0, 1'b0, DST_V);
            6'd29: u = mk_uop(OPD_DZ,  OPD_QZ,  1'b1, 1'b0, 1'b0, 1'b1, DST_V);
            6'd30: u = mk_uop(OPD_E2X, OPD_QX,  1'b0, 1'b0, 1'b1, 1'b0, DST_NUM);
            6'd31: u = mk_uop(OPD_E2X, OPD_QX,  1'b1, 1'b0, 1'b0, 1'b0, DST_NUM);
            6'd32: u = mk_uop(OPD_E2Y, OPD_QY,  1'b0, 1'b0, 1'b0, 1'b0, DST_NUM);
            6'd33: u = mk_uop(OPD_E2Y, OPD_QY,  1'b1, 1'b0, 1'b0, 1'b0, DST_NUM);
            6'd34: u = mk_uop(OPD_E2Z, OPD_QZ,  1'b0, 1'b0, 1'b0, 1'b0, DST_NUM);
            6'd35: u = mk_uop(OPD_E2Z, OPD_QZ,  1'b1, 1'b0, 1'b0, 1'b1, DST_NUM);
            default: u = mk_uop(OPD_E1X, OPD_E1X, 1'b0, 1'b0, 1'b0, 1'b0, DST_PX);
        endcase
        return u;
    endfunction

endpackage

[rtl/rtn_ctrl.sv]
module rtn_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output rtn_pkg::t_cmd o_cmd,
    input  rtn_pkg::t_sts i_sts
);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_DRAIN, S_CHECK, S_DIVI, S_DIV, S_DONE
    } t_state;

    t_state                         r_state;
    logic [rtn_pkg::UOP_CNT_W-1:0]  r_cnt;
    logic                           r_ovalid;
    logic                           out_free;

    assign out_free    = !r_ovalid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.uop      = rtn_pkg::uop_rom(r_cnt);
        o_cmd.load     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.issue    = (r_state == S_MUL);
        o_cmd.check    = (r_state == S_CHECK);
        o_cmd.div_init = (r_state == S_DIVI) && i_sts.cand;
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.finish   = (r_state == S_DONE) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_MUL;
                        r_cnt   <= '0;
                    end
                end
                S_MUL: begin
                    if (r_cnt == rtn_pkg::UOP_CNT_W'(rtn_pkg::UOP_COUNT - 1)) begin
                        r_state <= S_DRAIN;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DRAIN: r_state <= S_CHECK;
                S_CHECK: r_state <= S_DIVI;
                S_DIVI: begin
                    // skip the divider when the triangle already misses
                    r_state <= i_sts.cand ? S_DIV : S_DONE;
                    r_cnt   <= '0;
                end
                S_DIV: begin
                    if (r_cnt == rtn_pkg::UOP_CNT_W'(rtn_pkg::Q_W - 1)) begin
                        r_state <= S_DONE;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DONE: begin
                    if (out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase

            if (o_cmd.finish) r_ovalid <= 1'b1;
            else if (i_out_ready) r_ovalid <= 1'b0;
        end
    end

    a_load_starts_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_MUL) && (r_cnt == '0))
        else $error("transfer in did not start the multiply sequence");

    a_div_needs_cand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> i_sts.cand)
        else $error("division running for a rejected triangle");

    a_issue_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.issue |-> (r_cnt < rtn_pkg::UOP_CNT_W'(rtn_pkg::UOP_COUNT)))
        else $error("multiply step beyond program");

    a_finish_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_ovalid && (r_state == S_IDLE))
        else $error("finished result not presented");

endmodule

[rtl/rtn_datapath.sv]
module rtn_datapath #(
    parameter int TAG_WIDTH = rtn_pkg::TAG_WIDTH_DEF,
    parameter int FRAC_BITS = rtn_pkg::FRAC_BITS_DEF,
    parameter int IN_W      = 8,
    parameter int OUT_W     = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rtn_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rtn_pkg::COORD_W-1:0]   i_cfg_data,
    input  logic [IN_W-1:0]               i_in_data,
    input  logic                          i_in_new_ray,
    input  rtn_pkg::t_cmd                 i_cmd,
    output rtn_pkg::t_sts                 o_sts,
    output logic [OUT_W-1:0]              o_out_data
);

    localparam int CW  = rtn_pkg::COORD_W;
    localparam int VW  = rtn_pkg::VEC_W;
    localparam int PW  = rtn_pkg::PQ_W;
    localparam int AW  = rtn_pkg::ACC_W;
    localparam int QW  = rtn_pkg::Q_W;
    localparam int LW  = rtn_pkg::LO_W;
    localparam int NW  = AW + FRAC_BITS;

    // configuration
    logic signed [CW-1:0] r_org [3];
    logic signed [CW-1:0] r_dir [3];
    logic        [CW-1:0] r_eps;

    // per-item operands
    logic signed [VW-1:0] r_e1 [3];
    logic signed [VW-1:0] r_e2 [3];
    logic signed [VW-1:0] r_s  [3];
    logic [TAG_WIDTH-1:0] r_tag;
    logic                 r_new_ray;

    logic signed [PW-1:0] r_p [3];
    logic signed [PW-1:0] r_q [3];
    logic signed [AW-1:0] r_det, r_u, r_v, r_num;

    // multiplier stage and accumulator
    logic signed [VW-1:0]              mul_a;
    logic signed [rtn_pkg::MB_W-1:0]   mul_b;
    logic signed [VW-1:0]              vec_b;
    logic signed [PW-1:0]              pq_b;
    logic                              b_is_pq;
    logic signed [rtn_pkg::PROD_W-1:0] r_prod;
    logic                              r_pv;
    rtn_pkg::t_uop                     r_pctl;
    logic signed [AW-1:0]              r_acc;
    logic signed [AW-1:0]              addend, acc_base, acc_next;

    // test and divider
    logic signed [AW-1:0] eps_ext, neps, uv;
    logic                 pos_side, neg_side, pos_ok, neg_ok, behind, cand_c;
    logic                 r_cand, r_sat;
    logic [AW-1:0]        r_abs_num, r_abs_det, r_rem;
    logic [NW-1:0]        n_full;
    logic [AW-1:0]        n_hi;
    logic [AW:0]          trial;
    logic                 ge;
    logic [QW-1:0]        r_nlo, r_quo;

    // nearest tracking
    logic [QW-1:0]        r_near;
    logic [TAG_WIDTH-1:0] r_face;
    logic                 r_seen;
    logic [QW-1:0]        t_val, near_eff;
    logic                 hit;
    logic [TAG_WIDTH-1:0] face_after;
    logic                 seen_after;
    logic [OUT_W-1:0]     r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0] <= '0;
            r_org[1] <= '0;
            r_org[2] <= '0;
            r_dir[0] <= '0;
            r_dir[1] <= '0;
            r_dir[2] <= rtn_pkg::DIR_Z_RST;
            r_eps    <= rtn_pkg::DET_EPS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rtn_pkg::CFG_ORIGIN_X: r_org[0] <= i_cfg_data;
                rtn_pkg::CFG_ORIGIN_Y: r_org[1] <= i_cfg_data;
                rtn_pkg::CFG_ORIGIN_Z: r_org[2] <= i_cfg_data;
                rtn_pkg::CFG_DIR_X:    r_dir[0] <= i_cfg_data;
                rtn_pkg::CFG_DIR_Y:    r_dir[1] <= i_cfg_data;
                rtn_pkg::CFG_DIR_Z:    r_dir[2] <= i_cfg_data;
                rtn_pkg::CFG_DET_EPS:  r_eps    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < 3; i++) begin
                r_e1[i] <= VW'(signed'(i_in_data[(3 + i)*CW +: CW]))
                         - VW'(signed'(i_in_data[i*CW +: CW]));
                r_e2[i] <= VW'(signed'(i_in_data[(6 + i)*CW +: CW]))
                         - VW'(signed'(i_in_data[i*CW +: CW]));
                r_s[i]  <= VW'(r_org[i]) - VW'(signed'(i_in_data[i*CW +: CW]));
            end
            r_tag     <= i_in_data[9*CW +: TAG_WIDTH];
            r_new_ray <= i_in_new_ray;
        end
    end

    always_comb begin
        unique case (i_cmd.uop.a)
            rtn_pkg::OPD_E1X: mul_a = r_e1[0];
            rtn_pkg::OPD_E1Y: mul_a = r_e1[1];
            rtn_pkg::OPD_E1Z: mul_a = r_e1[2];
            rtn_pkg::OPD_E2X: mul_a = r_e2[0];
            rtn_pkg::OPD_E2Y: mul_a = r_e2[1];
            rtn_pkg::OPD_E2Z: mul_a = r_e2[2];
            rtn_pkg::OPD_SX:  mul_a = r_s[0];
            rtn_pkg::OPD_SY:  mul_a = r_s[1];
            rtn_pkg::OPD_SZ:  mul_a = r_s[2];
            rtn_pkg::OPD_DX:  mul_a = VW'(r_dir[0]);
            rtn_pkg::OPD_DY:  mul_a = VW'(r_dir[1]);
            rtn_pkg::OPD_DZ:  mul_a = VW'(r_dir[2]);
            default:          mul_a = '0;
        endcase
    end

    always_comb begin
        vec_b   = '0;
        pq_b    = '0;
        b_is_pq = 1'b0;
        unique case (i_cmd.uop.b)
            rtn_pkg::OPD_E1X: vec_b = r_e1[0];
            rtn_pkg::OPD_E1Y: vec_b = r_e1[1];
            rtn_pkg::OPD_E1Z: vec_b = r_e1[2];
            rtn_pkg::OPD_E2X: vec_b = r_e2[0];
            rtn_pkg::OPD_E2Y: vec_b = r_e2[1];
            rtn_pkg::OPD_E2Z: vec_b = r_e2[2];
            rtn_pkg::OPD_SX:  vec_b = r_s[0];
            rtn_pkg::OPD_SY:  vec_b = r_s[1];
            rtn_pkg::OPD_SZ:  vec_b = r_s[2];
            rtn_pkg::OPD_DX:  vec_b = VW'(r_dir[0]);
            rtn_pkg::OPD_DY:  vec_b = VW'(r_dir[1]);
            rtn_pkg::OPD_DZ:  vec_b = VW'(r_dir[2]);
            rtn_pkg::OPD_PX: begin pq_b = r_p[0]; b_is_pq = 1'b1; end
            rtn_pkg::OPD_PY: begin pq_b = r_p[1]; b_is_pq = 1'b1; end
            rtn_pkg::OPD_PZ: begin pq_b = r_p[2]; b_is_pq = 1'b1; end
            rtn_pkg::OPD_QX: begin pq_b = r_q[0]; b_is_pq = 1'b1; end
            rtn_pkg::OPD_QY: begin pq_b = r_q[1]; b_is_pq = 1'b1; end
            rtn_pkg::OPD_QZ: begin pq_b = r_q[2]; b_is_pq = 1'b1; end
            default: ;
        endcase
        // low chunk unsigned, high chunk carries the sign
        if (!b_is_pq)
            mul_b = rtn_pkg::MB_W'(vec_b);
        else if (i_cmd.uop.hi)
            mul_b = rtn_pkg::MB_W'(signed'(pq_b[PW-1:LW]));
        else
            mul_b = signed'({1'b0, pq_b[LW-1:0]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_cmd.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_prod <= mul_a * mul_b;
            r_pctl <= i_cmd.uop;
        end
    end

    assign addend   = r_pctl.hi ? (AW'(r_prod) <<< LW) : AW'(r_prod);
    assign acc_base = r_pctl.first ? '0 : r_acc;
    assign acc_next = r_pctl.sub ? (acc_base - addend) : (acc_base + addend);

    always_ff @(posedge i_clk) begin
        if (r_pv) begin
            r_acc <= acc_next;
            if (r_pctl.last) begin
                unique case (r_pctl.dst)
                    rtn_pkg::DST_PX:  r_p[0] <= acc_next[PW-1:0];
                    rtn_pkg::DST_PY:  r_p[1] <= acc_next[PW-1:0];
                    rtn_pkg::DST_PZ:  r_p[2] <= acc_next[PW-1:0];
                    rtn_pkg::DST_QX:  r_q[0] <= acc_next[PW-1:0];
                    rtn_pkg::DST_QY:  r_q[1] <= acc_next[PW-1:0];
                    rtn_pkg::DST_QZ:  r_q[2] <= acc_next[PW-1:0];
                    rtn_pkg::DST_DET: r_det  <= acc_next;
                    rtn_pkg::DST_U:   r_u    <= acc_next;
                    rtn_pkg::DST_V:   r_v    <= acc_next;
                    rtn_pkg::DST_NUM: r_num  <= acc_next;
                    default: ;
                endcase
            end
        end
    end

    // edge tests on the side given by the determinant sign
    assign eps_ext  = signed'(AW'(r_eps));
    assign neps     = -eps_ext;
    assign uv       = r_u + r_v;
    assign pos_side = r_det > eps_ext;
    assign neg_side = r_det < neps;
    assign pos_ok   = !(r_u < 0) && !(r_u > r_det) && !(r_v < 0) && !(uv > r_det);
    assign neg_ok   = !(r_u > 0) && !(r_u < r_det) && !(r_v > 0) && !(uv < r_det);
    assign behind   = (r_num != '0) && (r_num[AW-1] != r_det[AW-1]);
    assign cand_c   = ((pos_side && pos_ok) || (neg_side && neg_ok)) && !behind;

    assign o_sts.cand = r_cand;

    assign n_full = {r_abs_num, {FRAC_BITS{1'b0}}};
    assign n_hi   = AW'(n_full >> QW);
    assign trial  = {r_rem, r_nlo[QW-1]};
    assign ge     = trial >= {1'b0, r_abs_det};

    always_ff @(posedge i_clk) begin
        if (i_cmd.check) begin
            r_cand    <= cand_c;
            r_abs_num <= r_num[AW-1] ? AW'(-r_num) : AW'(r_num);
            r_abs_det <= r_det[AW-1] ? AW'(-r_det) : AW'(r_det);
        end
        if (i_cmd.div_init) begin
            // quotient of 2^32 or more saturates
            r_sat <= n_hi >= r_abs_det;
            r_rem <= n_hi;
            r_nlo <= n_full[QW-1:0];
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? AW'(trial - {1'b0, r_abs_det}) : trial[AW-1:0];
            r_quo <= {r_quo[QW-2:0], ge};
            r_nlo <= r_nlo << 1;
        end
    end

    assign t_val      = r_sat ? '1 : r_quo;
    assign near_eff   = r_new_ray ? '1 : r_near;
    assign hit        = r_cand && (t_val <= near_eff);
    assign face_after = hit ? r_tag : (r_new_ray ? '0 : r_face);
    assign seen_after = hit || (!r_new_ray && r_seen);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near <= '1;
            r_face <= '0;
            r_seen <= 1'b0;
        end else if (i_cmd.finish) begin
            r_near <= hit ? t_val : near_eff;
            r_face <= face_after;
            r_seen <= seen_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out <= OUT_W'({seen_after, face_after, r_tag,
                             (hit ? t_val : {QW{1'b0}}), hit});
        end
    end

    assign o_out_data = r_out;

endmodule

[rtl/ray_triangle_nearest_hit_unit.sv]
// channel  | direction | handshake                       | payload
// ---------+-----------+---------------------------------+------------------------------------
// s_axis   | in        | i_s_axis_tvalid/o_s_axis_tready | triangle corners, face tag; new ray
// m_axis   | out       | o_m_axis_tvalid/i_m_axis_tready | hit, distance, tags, any-hit
// cfg      | in        | i_cfg_valid/o_cfg_ready         | register index, 32-bit data
//
// An item that misses an edge test passes through accept, 36 multiply steps on the
// shared 33x35 multiplier, drain, test, decide and divider setup, and result; one that
// reaches the divider adds 32 restoring steps of one quotient bit each.
// i_rst_n is synchronous: it restores the register reset values and clears the nearest hit.
// The finished result waits in an output register; a stalled m_axis holds the next item
// in its last cycle until the register is taken. Configuration is always ready.
module ray_triangle_nearest_hit_unit #(
    parameter int TAG_WIDTH = rtn_pkg::TAG_WIDTH_DEF,
    parameter int FRAC_BITS = rtn_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y, corner_b_z,
    // corner_c_x, corner_c_y, corner_c_z, face_tag, zero fill
    input  logic [((9*rtn_pkg::COORD_W + TAG_WIDTH + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    // new_ray
    input  logic [0:0]                    i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // hit, distance, echo_tag, nearest_tag, any_hit, zero fill
    output logic [((2 + rtn_pkg::Q_W + 2*TAG_WIDTH + 7) / 8) * 8 - 1:0] o_m_axis_tdata,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rtn_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rtn_pkg::COORD_W-1:0]   i_cfg_data
);

    localparam int IN_W  = ((9*rtn_pkg::COORD_W + TAG_WIDTH + 7) / 8) * 8;
    localparam int OUT_W = ((2 + rtn_pkg::Q_W + 2*TAG_WIDTH + 7) / 8) * 8;

    rtn_pkg::t_cmd cmd;
    rtn_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    rtn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    rtn_datapath #(
        .TAG_WIDTH (TAG_WIDTH),
        .FRAC_BITS (FRAC_BITS),
        .IN_W      (IN_W),
        .OUT_W     (OUT_W)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_data    (i_s_axis_tdata),
        .i_in_new_ray (i_s_axis_tuser[0]),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_out_data   (o_m_axis_tdata)
    );

endmodule

[verif/testbench.sv]
module testbench;

    localparam int        HALF_PERIOD = 6;
    localparam int        Q_ONE       = 65536;
    localparam int        STALL_LIMIT = 20000;
    localparam int        HOLD_CYCLES = 3000;
    localparam int        DRAIN_WAIT  = 100;
    localparam int        N_PHASES    = 8;
    localparam int        PHASE_ITEMS = 145;
    localparam int        IN_W        = ((9*rtn_pkg::COORD_W + 16 + 7) / 8) * 8;
    localparam int        OUT_W       = ((2 + rtn_pkg::Q_W + 2*16 + 7) / 8) * 8;
    // index beyond the register map: the block must drop the write
    localparam logic [rtn_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef logic signed [127:0] t_wide;

    typedef struct packed {
        logic [15:0]        tag;
        logic [8:0][31:0]   corner;  // a.x a.y a.z b.x b.y b.z c.x c.y c.z from index 0
        logic               new_ray;
    } t_tri;

    // same bit order as the low bits of m_axis tdata
    typedef struct packed {
        logic        any_hit;
        logic [15:0] nearest_tag;
        logic [15:0] echo_tag;
        logic [31:0] distance;
        logic        hit;
    } t_hit;

    typedef struct {
        t_tri item;
        bit   typed;
        t_hit res;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_s_axis_tvalid = 1'b0;
    logic               o_s_axis_tready;
    logic [IN_W-1:0]    i_s_axis_tdata = '0;
    logic [0:0]         i_s_axis_tuser = '0;
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0]   o_m_axis_tdata;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [rtn_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [rtn_pkg::COORD_W-1:0]   i_cfg_data = '0;

    // ray registers and nearest-hit state as the block should hold them
    logic [31:0] ray_reg [0:6];
    logic [31:0] near_dist;
    logic [15:0] near_face;
    logic        seen_hit;

    t_hit  hits_due [$];
    t_row  dir_rows [$];
    int    n_fail = 0;
    int    idle_cycles = 0;
    bit    hold_req = 1'b0;
    bit    first_send = 1'b1;

    ray_triangle_nearest_hit_unit u_top (.*);

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    function automatic t_wide sx(logic [31:0] x);
        return {{96{x[31]}}, x};
    endfunction

    // exact two-sided intersection test plus nearest-hit update
    function automatic t_hit trace_tri(t_tri t);
        t_wide e1 [3], e2 [3], s [3], d [3], p [3], q [3];
        t_wide det, u, v, num, eps;
        logic [127:0] n_mag, d_mag, quo;
        logic [31:0] hit_len;
        bit ok;
        t_hit r;
        for (int i = 0; i < 3; i++) begin
            e1[i] = sx(t.corner[3+i]) - sx(t.corner[i]);
            e2[i] = sx(t.corner[6+i]) - sx(t.corner[i]);
            s[i]  = sx(ray_reg[i]) - sx(t.corner[i]);
            d[i]  = sx(ray_reg[3+i]);
        end
        p[0] = d[1]*e2[2] - d[2]*e2[1];
        p[1] = d[2]*e2[0] - d[0]*e2[2];
        p[2] = d[0]*e2[1] - d[1]*e2[0];
        q[0] = s[1]*e1[2] - s[2]*e1[1];
        q[1] = s[2]*e1[0] - s[0]*e1[2];
        q[2] = s[0]*e1[1] - s[1]*e1[0];
        det = e1[0]*p[0] + e1[1]*p[1] + e1[2]*p[2];
        u   = s[0]*p[0] + s[1]*p[1] + s[2]*p[2];
        v   = d[0]*q[0] + d[1]*q[1] + d[2]*q[2];
        num = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
        eps = {96'b0, ray_reg[rtn_pkg::CFG_DET_EPS]};
        if (det > eps)
            ok = !(u < 0 || u > det || v < 0 || u + v > det);
        else if (det < -eps)
            ok = !(u > 0 || u < det || v > 0 || u + v < det);
        else
            ok = 1'b0;
        // behind the origin
        if (ok && num != 0 && ((num < 0) != (det < 0)))
            ok = 1'b0;
        hit_len = '0;
        if (ok) begin
            n_mag   = (num < 0) ? -num : num;
            d_mag   = (det < 0) ? -det : det;
            quo     = (n_mag << 16) / d_mag;
            hit_len = (quo[127:32] != 0) ? 32'hFFFF_FFFF : quo[31:0];
        end
        if (t.new_ray) begin
            near_dist = 32'hFFFF_FFFF;
            near_face = '0;
            seen_hit  = 1'b0;
        end
        r.hit = ok && hit_len <= near_dist;
        if (r.hit) begin
            near_dist = hit_len;
            near_face = t.tag;
            seen_hit  = 1'b1;
        end
        r.distance    = r.hit ? hit_len : 32'd0;
        r.echo_tag    = t.tag;
        r.nearest_tag = near_face;
        r.any_hit     = seen_hit;
        return r;
    endfunction

    function automatic t_tri mk_tri(int ax, int ay, int az, int bx, int by, int bz,
                                    int cx, int cy, int cz, bit nr, int tag);
        t_tri t;
        t.corner  = {cz, cy, cx, bz, by, bx, az, ay, ax};
        t.new_ray = nr;
        t.tag     = 16'(tag);
        return t;
    endfunction

    task automatic add_row(t_tri t, bit typed, t_hit res);
        t_row row;
        row.item  = t;
        row.typed = typed;
        row.res   = res;
        dir_rows.insert(dir_rows.size(), row);
    endtask

    task automatic send_tri(t_tri t, bit typed, t_hit typed_res);
        int r, gap;
        t_hit pred;
        r = $urandom_range(0, 99);
        gap = (r < 50) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 60);
        @(negedge i_clk);
        if (gap > 0 && !first_send) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        first_send = 1'b0;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {t.tag, t.corner};
        i_s_axis_tuser  <= t.new_ray;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pred = trace_tri(t);
        hits_due.insert(hits_due.size(), typed ? typed_res : pred);
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        first_send = 1'b1;
    endtask

    task automatic wait_idle();
        while (hits_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // write all seven registers, then a stray index
    task automatic load_ray(logic [31:0] val [0:6]);
        for (int i = 0; i <= 7; i++) begin
            @(negedge i_clk);
            i_cfg_valid <= 1'b1;
            i_cfg_index <= (i == 7) ? CFG_UNUSED : rtn_pkg::CFG_IDX_W'(i);
            i_cfg_data  <= (i == 7) ? $urandom : val[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            if (i < 7) ray_reg[i] = val[i];
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] small_val(int mag);
        return $urandom_range(0, 2*mag) - mag;
    endfunction

    // triangle or quad placed so the line of the ray runs through its centre
    task automatic send_aimed(bit quad);
        longint k, pt [3], r1 [3], r2 [3];
        int scale;
        t_tri t0, t1;
        k = longint'($urandom_range(0, 9*Q_ONE)) - Q_ONE;
        scale = 1 << $urandom_range(4, 22);
        for (int i = 0; i < 3; i++) begin
            pt[i] = longint'(sx(ray_reg[i])) + ((longint'(sx(ray_reg[3+i])) * k) >>> 16);
            r1[i] = longint'($urandom_range(0, 2*scale)) - scale;
            r2[i] = longint'($urandom_range(0, 2*scale)) - scale;
        end
        t0.new_ray = ($urandom_range(0, 9) == 0);
        t0.tag = 16'($urandom);
        for (int i = 0; i < 3; i++) begin
            t0.corner[i]   = 32'(pt[i] + r1[i]);
            t0.corner[3+i] = 32'(pt[i] + r2[i]);
            t0.corner[6+i] = quad ? 32'(pt[i] - r1[i]) : 32'(pt[i] - r1[i] - r2[i]);
        end
        send_tri(t0, 1'b0, '0);
        if (quad) begin
            t1.new_ray = 1'b0;
            t1.tag = t0.tag;
            for (int i = 0; i < 3; i++) begin
                t1.corner[i]   = t0.corner[6+i];
                t1.corner[3+i] = 32'(pt[i] - r2[i]);
                t1.corner[6+i] = t0.corner[i];
            end
            send_tri(t1, 1'b0, '0);
        end
    endtask

    task automatic send_noise();
        t_tri t;
        bit full;
        full = $urandom_range(0, 1);
        for (int i = 0; i < 9; i++)
            t.corner[i] = full ? $urandom : small_val(4*Q_ONE);
        t.new_ray = ($urandom_range(0, 7) == 0);
        t.tag = 16'($urandom);
        send_tri(t, 1'b0, '0);
    endtask

    // receiver: random stalls, calm stretches, one long hold-off on request
    initial begin
        int r, calm_left;
        bit calm;
        calm = 1'b0;
        calm_left = 100;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (--calm_left <= 0) begin
                    calm = !calm;
                    calm_left = $urandom_range(50, 300);
                end
                if (calm) begin
                    i_m_axis_tready <= 1'b1;
                end else if (r < 5) begin
                    i_m_axis_tready <= 1'b0;
                    repeat ($urandom_range(10, 60)) @(negedge i_clk);
                end else begin
                    i_m_axis_tready <= (r >= 35);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_hit got, want;
        if (o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata[65:0];
            if (hits_due.size() == 0) begin
                $error("result transfer with nothing expected");
                n_fail++;
            end else begin
                want = hits_due.pop_front();
                if (got.hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, got.hit);
                    n_fail++;
                end
                if (got.distance !== want.distance) begin
                    $error("distance: expected %0h, got %0h", want.distance, got.distance);
                    n_fail++;
                end
                if (got.echo_tag !== want.echo_tag) begin
                    $error("echo_tag: expected %0h, got %0h", want.echo_tag, got.echo_tag);
                    n_fail++;
                end
                if (got.nearest_tag !== want.nearest_tag) begin
                    $error("nearest_tag: expected %0h, got %0h",
                           want.nearest_tag, got.nearest_tag);
                    n_fail++;
                end
                if (got.any_hit !== want.any_hit) begin
                    $error("any_hit: expected %0d, got %0d", want.any_hit, got.any_hit);
                    n_fail++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        logic [31:0] val [0:6];
        int U;
        U = Q_ONE;
        for (int i = 0; i < 7; i++) ray_reg[i] = '0;
        ray_reg[rtn_pkg::CFG_DIR_Z]   = rtn_pkg::DIR_Z_RST;
        ray_reg[rtn_pkg::CFG_DET_EPS] = rtn_pkg::DET_EPS_RST;
        near_dist = 32'hFFFF_FFFF;
        near_face = '0;
        seen_hit  = 1'b0;

        // reset ray: origin 0, direction +z
        add_row(mk_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1), 1'b1,
                '{1'b0, 16'h0, 16'h1, 32'd0, 1'b0});
        add_row(mk_tri('h7fffffff, 'h7fffffff, 'h7fffffff, 'h7fffffff,
                       'h7fffffff, 'h7fffffff, 'h7fffffff, 'h7fffffff,
                       'h7fffffff, 0, 'hffff), 1'b1,
                '{1'b0, 16'h0, 16'hffff, 32'd0, 1'b0});
        add_row(mk_tri('h80000000, 'h80000000, 'h80000000, 'h80000000,
                       'h80000000, 'h80000000, 'h80000000, 'h80000000,
                       'h80000000, 0, 0), 1'b1,
                '{1'b0, 16'h0, 16'h0, 32'd0, 1'b0});
        add_row(mk_tri(-U, -U, U, U, -U, U, 0, U, U, 1, 5), 1'b1,
                '{1'b1, 16'h5, 16'h5, 32'd65536, 1'b1});
        add_row(mk_tri(-U, -U, 2*U, U, -U, 2*U, 0, U, 2*U, 0, 6), 1'b1,
                '{1'b1, 16'h5, 16'h6, 32'd0, 1'b0});
        add_row(mk_tri(-U, -U, U/2, U, -U, U/2, 0, U, U/2, 0, 7), 1'b1,
                '{1'b1, 16'h7, 16'h7, 32'd32768, 1'b1});
        add_row(mk_tri(-U, -U, -U, U, -U, -U, 0, U, -U, 0, 8), 1'b1,
                '{1'b1, 16'h7, 16'h8, 32'd0, 1'b0});
        // opposite winding, touching a corner, at the origin, equal distance
        add_row(mk_tri(U, -U, U/4, -U, -U, U/4, 0, U, U/4, 0, 9), 1'b0, '0);
        add_row(mk_tri(0, 0, U/8, U, 0, U/8, 0, U, U/8, 0, 10), 1'b0, '0);
        add_row(mk_tri(-U, -U, 0, U, -U, 0, 0, U, 0, 0, 11), 1'b0, '0);
        add_row(mk_tri(-U, -U, -U, U, -U, -U, 0, U, -U, 1, 12), 1'b1,
                '{1'b0, 16'h0, 16'hc, 32'd0, 1'b0});
        add_row(mk_tri(-U, -U, U, U, -U, U, 0, U, U, 0, 13), 1'b0, '0);
        add_row(mk_tri(U, -U, U, -U, -U, U, 0, U, U, 0, 14), 1'b0, '0);
        add_row(mk_tri(-U, -U, 3*U, U, -U, 3*U, U, U, 3*U, 1, 15), 1'b0, '0);
        add_row(mk_tri(U, U, 3*U, -U, U, 3*U, -U, -U, 3*U, 0, 15), 1'b0, '0);
        add_row(mk_tri('h80000000, 'h7fffffff, 1, 'h7fffffff, 'h80000000, -1,
                       0, 'h7fffffff, 'h80000000, 1, 'h5a5a), 1'b0, '0);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_tri(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);
        drop_valid();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_idle();
            for (int i = 0; i < 7; i++) val[i] = ray_reg[i];
            case (ph)
                0: ;
                1: begin
                    for (int i = 0; i < 3; i++) val[i] = small_val(4*U);
                    for (int i = 3; i < 6; i++) val[i] = small_val(2*U);
                end
                2: begin
                    for (int i = 0; i < 6; i++) val[i] = small_val(8*U);
                    val[rtn_pkg::CFG_DET_EPS] = '0;
                end
                3: begin
                    for (int i = 3; i < 6; i++) val[i] = small_val(U);
                    val[rtn_pkg::CFG_DET_EPS] = 32'hFFFF_FFFF;
                end
                4: begin
                    // tiny direction: distances saturate
                    val[rtn_pkg::CFG_ORIGIN_X] = 32'h7FFF_FFFF;
                    val[rtn_pkg::CFG_ORIGIN_Y] = 32'h8000_0000;
                    val[rtn_pkg::CFG_ORIGIN_Z] = 32'h0;
                    val[rtn_pkg::CFG_DIR_X] = 32'd0;
                    val[rtn_pkg::CFG_DIR_Y] = 32'd1;
                    val[rtn_pkg::CFG_DIR_Z] = 32'hFFFF_FFFF;
                    val[rtn_pkg::CFG_DET_EPS] = '0;
                end
                5: begin
                    for (int i = 0; i < 3; i++) val[i] = '0;
                    for (int i = 3; i < 6; i++) val[i] = 32'h8000_0000;
                    val[rtn_pkg::CFG_DET_EPS] = 32'h0000_FFFF;
                end
                6: for (int i = 0; i < 7; i++) val[i] = $urandom;
                default: begin
                    for (int i = 0; i < 3; i++) val[i] = small_val(U);
                    for (int i = 3; i < 6; i++) val[i] = small_val(3*U);
                    val[rtn_pkg::CFG_DET_EPS] = rtn_pkg::DET_EPS_RST;
                    hold_req = 1'b1;
                end
            endcase
            if (ph != 0) load_ray(val);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                int r;
                r = $urandom_range(0, 99);
                if (r < 60) send_aimed(1'b0);
                else if (r < 80) send_aimed(1'b1);
                else send_noise();
            end
            drop_valid();
        end

        while (hits_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (n_fail == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[ray_triangle_nearest_hit_unit.f]
rtl/rtn_pkg.sv
rtl/rtn_ctrl.sv
rtl/rtn_datapath.sv
rtl/ray_triangle_nearest_hit_unit.sv
verif/testbench.sv
